@@ sv/rdmc_pkg.sv @@
// Shared types, constants and a helper function for the maze carver.
package rdmc_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam int RAND_W      = 32;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int COORD_OUT_W = 4;

  localparam logic [CFG_W-1:0] CFG_COUNT_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef struct packed {
    logic [RAND_W-1:0] random_word;
    logic              restart;
  } in_word_t;

  typedef struct packed {
    logic [COORD_OUT_W-1:0] from_row;
    logic [COORD_OUT_W-1:0] from_col;
    logic [1:0]             carve_dir;
    logic [COORD_OUT_W-1:0] to_row;
    logic [COORD_OUT_W-1:0] to_col;
    logic                   done_res;
  } out_word_t;

  // Returns the direction of the n-th set bit of the candidate mask,
  // counting from the up direction.
  function automatic dir_t nth_set(logic [3:0] mask, logic [1:0] n);
    logic [2:0] seen;
    dir_t       sel;
    seen = 3'd0;
    sel  = DIR_UP;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == {1'b0, n}) begin
          sel = dir_t'(i[1:0]);
        end
        seen = seen + 3'd1;
      end
    end
    return sel;
  endfunction

endpackage

@@ sv/rdmc_in_if.sv @@
// Valid/ready channel that carries one input word of the maze carver.
interface rdmc_in_if;
  import rdmc_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/rdmc_out_if.sv @@
// Valid/ready channel that carries one result word of the maze carver.
interface rdmc_out_if;
  import rdmc_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/random_dfs_maze_carver_top.sv @@
// Top level of the randomized depth-first maze carver.
//
// The block carves a perfect maze by depth-first search with an explicit
// stack, starting at the origin cell. Each word accepted on in_ch brings a
// 32-bit random word and a restart flag; each one yields exactly one word on
// out_ch: either the passage just carved (from cell, direction, to cell) or
// a done word once the stack has run empty. The user must write row_count
// and col_count (cfg_we/cfg_index/cfg_wdata) only while the block is idle;
// the block itself does not enforce it.
//
// One shared neighbor unit computes neighbor coordinates and the
// visited-store address, one direction per cycle. A carve without pops runs
// through the accept, the scan of the four directions, the carve and the
// hand-off to the output register; every popped cell adds a scan and a stack
// read. A restart first runs a clearing pass over all MAX_ROWS*MAX_COLS
// cells of the visited store (256 at the defaults). The same clearing pass
// runs right after reset, during which in_ch is not ready. The result sits
// in an output register, so a new word is accepted while the previous result
// waits; a stalled receiver only holds up the next hand-off to that register.
module random_dfs_maze_carver_top #(
  parameter int MAX_ROWS = rdmc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rdmc_pkg::MAX_COLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rdmc_in_if.sink                       in_ch,
  rdmc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [rdmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rdmc_pkg::CFG_W-1:0]     cfg_wdata
);
  import rdmc_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int SDW   = $clog2(CELLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CLW   = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);

  // Result word of a finished maze: only the done flag is set.
  localparam out_word_t DONE_WORD = '{from_row: '0, from_col: '0, carve_dir: '0,
                                      to_row: '0, to_col: '0, done_res: 1'b1};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_POP,
    ST_CARVE,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  row_cfg_r;
  logic [CFG_W-1:0]  col_cfg_r;
  logic [AW-1:0]     clr_idx_r;
  logic              pending_r;
  logic [RAND_W-1:0] word_r;
  logic [SDW-1:0]    depth_r;
  logic [RW-1:0]     top_row_r;
  logic [CLW-1:0]    top_col_r;
  logic [2:0]        scan_idx_r;
  logic              nb_ok_r;
  logic [3:0]        cand_r;
  logic [1:0]        pick_r;
  out_word_t         res_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  logic              vis_rd_r;
  logic [RW+CLW-1:0] stk_rd_r;

  logic vis_mem [CELLS];
  logic [RW+CLW-1:0] stk_mem [CELLS];

  // Effective grid size: zero counts as one, anything above the maximum
  // counts as the maximum.
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cols_eff;

  always_comb begin
    if (row_cfg_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(row_cfg_r) > 32'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(row_cfg_r);
    end
    if (col_cfg_r == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(col_cfg_r) > 32'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = CCW'(col_cfg_r);
    end
  end

  // Shared neighbor unit. During the scan it walks the four directions in
  // order; during the carve it serves the chosen direction.
  dir_t           carve_dir;
  dir_t           nb_dir;
  logic [RCW-1:0] nb_row_w;
  logic [CCW-1:0] nb_col_w;
  logic           nb_step_ok;
  logic           nb_ok;
  logic [AW-1:0]  nb_addr;

  assign carve_dir = nth_set(cand_r, pick_r);

  always_comb begin
    nb_dir     = (state_r == ST_CARVE) ? carve_dir : dir_t'(scan_idx_r[1:0]);
    nb_row_w   = RCW'(top_row_r);
    nb_col_w   = CCW'(top_col_r);
    nb_step_ok = 1'b1;
    unique case (nb_dir)
      DIR_UP: begin
        nb_step_ok = (top_row_r != '0);
        nb_row_w   = RCW'(top_row_r) - RCW'(1);
      end
      DIR_RIGHT: begin
        nb_col_w = CCW'(top_col_r) + CCW'(1);
      end
      DIR_DOWN: begin
        nb_row_w = RCW'(top_row_r) + RCW'(1);
      end
      DIR_LEFT: begin
        nb_step_ok = (top_col_r != '0);
        nb_col_w   = CCW'(top_col_r) - CCW'(1);
      end
      default: begin
        nb_step_ok = 1'b0;
      end
    endcase
    nb_ok   = nb_step_ok && (nb_row_w < rows_eff) && (nb_col_w < cols_eff);
    nb_addr = AW'(nb_row_w) * AW'(MAX_COLS) + AW'(nb_col_w);
  end

  // Candidate mask: the read of direction k is registered, so bit k lands
  // while direction k+1 is being read.
  logic       scan_bit;
  logic [3:0] cand_new;
  logic       has_cand;
  logic [1:0] pick_idx;

  always_comb begin
    scan_bit = nb_ok_r && !vis_rd_r;
    cand_new = cand_r;
    if (scan_idx_r != 3'd0) begin
      cand_new = cand_r | (4'(scan_bit) << (scan_idx_r - 3'd1));
    end
  end

  rdmc_pick u_pick (
    .cand_mask (cand_new),
    .rand_word (word_r),
    .has_cand  (has_cand),
    .pick_idx  (pick_idx)
  );

  // Memory write and read ports.
  logic              vis_we;
  logic [AW-1:0]     vis_waddr;
  logic              vis_wdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [RW+CLW-1:0] stk_wdata;
  logic [AW-1:0]     stk_raddr;
  logic              stk_room;

  assign stk_room  = (depth_r < SDW'(CELLS));
  assign stk_raddr = AW'(depth_r - SDW'(2));

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = nb_addr;
    vis_wdata = 1'b1;
    stk_we    = 1'b0;
    stk_waddr = AW'(depth_r);
    stk_wdata = {RW'(nb_row_w), CLW'(nb_col_w)};
    if (state_r == ST_CLEAR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_idx_r;
      vis_wdata = (clr_idx_r == '0);
      stk_we    = (clr_idx_r == '0);
      stk_waddr = '0;
      stk_wdata = '0;
    end else if (state_r == ST_CARVE) begin
      vis_we = 1'b1;
      stk_we = stk_room;
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_r <= vis_mem[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  // Handshakes.
  logic in_fire;
  logic out_free;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Sequencer with the registers it owns.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      pending_r   <= 1'b0;
      depth_r     <= SDW'(1);
      top_row_r   <= '0;
      top_col_r   <= '0;
      scan_idx_r  <= '0;
      cand_r      <= '0;
      out_valid_r <= 1'b0;
      row_cfg_r   <= CFG_COUNT_RESET;
      col_cfg_r   <= CFG_COUNT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROW_COUNT: row_cfg_r <= cfg_wdata;
          CFG_COL_COUNT: col_cfg_r <= cfg_wdata;
          default: ;
        endcase
      end

      // In the emit state the flag is owned by the hand-off below.
      if (out_valid_r && out_ch.ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          if (clr_idx_r == AW'(CELLS - 1)) begin
            clr_idx_r  <= '0;
            depth_r    <= SDW'(1);
            top_row_r  <= '0;
            top_col_r  <= '0;
            scan_idx_r <= '0;
            cand_r     <= '0;
            state_r    <= pending_r ? ST_SCAN : ST_IDLE;
            pending_r  <= 1'b0;
          end else begin
            clr_idx_r <= clr_idx_r + AW'(1);
          end
        end

        ST_IDLE: begin
          if (in_fire) begin
            word_r     <= in_ch.data.random_word;
            scan_idx_r <= '0;
            cand_r     <= '0;
            if (in_ch.data.restart) begin
              pending_r <= 1'b1;
              clr_idx_r <= '0;
              state_r   <= ST_CLEAR;
            end else if (depth_r == '0) begin
              res_r   <= DONE_WORD;
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          nb_ok_r    <= nb_ok;
          cand_r     <= cand_new;
          scan_idx_r <= scan_idx_r + 3'd1;
          if (scan_idx_r == 3'd4) begin
            if (has_cand) begin
              pick_r  <= pick_idx;
              state_r <= ST_CARVE;
            end else if (depth_r == SDW'(1)) begin
              depth_r <= '0;
              res_r   <= DONE_WORD;
              state_r <= ST_EMIT;
            end else begin
              // Dead end: the cell below the top comes back from the stack
              // memory next cycle.
              depth_r <= depth_r - SDW'(1);
              state_r <= ST_POP;
            end
          end
        end

        ST_POP: begin
          top_row_r  <= stk_rd_r[RW+CLW-1:CLW];
          top_col_r  <= stk_rd_r[CLW-1:0];
          scan_idx_r <= '0;
          cand_r     <= '0;
          state_r    <= ST_SCAN;
        end

        ST_CARVE: begin
          res_r <= '{from_row:  COORD_OUT_W'(top_row_r),
                     from_col:  COORD_OUT_W'(top_col_r),
                     carve_dir: carve_dir,
                     to_row:    COORD_OUT_W'(RW'(nb_row_w)),
                     to_col:    COORD_OUT_W'(CLW'(nb_col_w)),
                     done_res:  1'b0};
          if (stk_room) begin
            depth_r   <= depth_r + SDW'(1);
            top_row_r <= RW'(nb_row_w);
            top_col_r <= CLW'(nb_col_w);
          end
          state_r <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/rdmc_pick.sv @@
// Scales the random word by the number of open neighbors to pick one of them.
module rdmc_pick (
  input  logic [3:0]                cand_mask,
  input  logic [rdmc_pkg::RAND_W-1:0] rand_word,
  output logic                      has_cand,
  output logic [1:0]                pick_idx
);
  import rdmc_pkg::*;

  localparam int PW = RAND_W + 3;

  logic [2:0]    cand_count;
  logic [PW-1:0] product;

  always_comb begin
    cand_count = 3'($countones(cand_mask));
    product    = PW'(rand_word) * PW'(cand_count);
  end

  // The count is at most four, so the top product bit stays clear and the
  // pick always lands below the count.
  assign has_cand = |cand_mask;
  assign pick_idx = product[RAND_W+1:RAND_W];

endmodule
